// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the run queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/prqps_pkg.sv -----
// ----------------------------------------------------------------------------
// Run queue package
// Types, codes and constants shared by the run queue modules.
// ----------------------------------------------------------------------------
package prqps_pkg;

    localparam int MAX_PROCS_DEF = 64;
    localparam int ID_W          = 6;
    localparam int PRI_W         = 2;
    localparam int TQ_W          = 6;
    localparam int STATUS_W      = 3;
    localparam int COUNT_W       = 7;
    localparam int LEVEL_W       = 5;

    localparam logic [TQ_W-1:0] TQ_RESET  = 6'd4;
    localparam logic [TQ_W-1:0] TQ_OFFSET = 6'd4;
    // Worse than any real priority, so the first entry compared always replaces it.
    localparam logic [PRI_W:0]  PRI_NONE  = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_UNLINK = 3'd2,
        OP_ROTATE = 3'd3,
        OP_TEST   = 3'd4,
        OP_SELECT = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_STATUS = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_ABSENT = 3'd2,
        ST_FULL   = 3'd3,
        ST_DUP    = 3'd4
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_slot;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // write the pushed entry at the position
        logic shift;  // every cell takes its right neighbor
        logic keep;   // the front entry wraps to the position while shifting
    } t_cell_ctl;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ID_W-1:0]     selected_id;
        logic                selected_valid;
        logic [ID_W-1:0]     front_id;
        logic                queue_empty;
        logic [COUNT_W-1:0]  entry_count;
        logic [LEVEL_W-1:0]  pushed_level;
    } t_rsp;

endpackage

// ----- design/prqps_req_if.sv -----
// ----------------------------------------------------------------------------
// Run queue request channel
// Valid/ready channel carrying one queue operation per beat.
// ----------------------------------------------------------------------------
interface prqps_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [5:0] proc_id;
    logic [1:0] entry_priority;

    modport source (output valid, output opcode, output proc_id, output entry_priority,
                    input ready);
    modport sink   (input valid, input opcode, input proc_id, input entry_priority,
                    output ready);
endinterface

// ----- design/prqps_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Run queue response channel
// Valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface prqps_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       found;
    logic [5:0] selected_id;
    logic       selected_valid;
    logic [5:0] front_id;
    logic       queue_empty;
    logic [6:0] entry_count;
    logic [4:0] pushed_level;

    modport source (output valid, output status, output found, output selected_id,
                    output selected_valid, output front_id, output queue_empty,
                    output entry_count, output pushed_level, input ready);
    modport sink   (input valid, input status, input found, input selected_id,
                    input selected_valid, input front_id, input queue_empty,
                    input entry_count, input pushed_level, output ready);
endinterface

// ----- design/prqps_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Run queue configuration channel
// Valid/ready write channel for the slice tick count register.
// ----------------------------------------------------------------------------
interface prqps_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] slice_ticks;

    modport source (output valid, output slice_ticks, input ready);
    modport sink   (input valid, input slice_ticks, output ready);
endinterface

// ----- design/prqps_cell.sv -----
// ----------------------------------------------------------------------------
// Run queue cell
// One queue position: holds an id and its priority, loads a pushed entry,
// shifts from its right neighbor or takes the wrapped front entry.
// ----------------------------------------------------------------------------
module prqps_cell #(
    parameter int MAX_PROCS = prqps_pkg::MAX_PROCS_DEF,
    parameter int IDX       = 0
) (
    input  logic                               i_clk,
    input  prqps_pkg::t_cell_ctl               i_ctl,
    input  logic [$clog2(MAX_PROCS+1)-1:0]     i_pos,
    input  prqps_pkg::t_slot                   i_push,
    input  prqps_pkg::t_slot                   i_right,
    input  prqps_pkg::t_slot                   i_head,
    output prqps_pkg::t_slot                   o_slot
);
    import prqps_pkg::*;

    localparam int CW = $clog2(MAX_PROCS + 1);

    t_slot r_slot;
    logic  w_here;

    assign w_here = (i_pos == CW'(IDX));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_here) begin
            r_slot <= i_push;
        end else if (i_ctl.shift) begin
            r_slot <= (i_ctl.keep && w_here) ? i_head : i_right;
        end
    end

    assign o_slot = r_slot;

endmodule

// ----- design/process_ring_queue_priority_select.sv -----
// Push, pop, member test, clear and status finish without walking the ring.
// Unlink and select walk one full turn over the N entries, and rotate walks until the
// target sits at the front, where N is the entry count. The chain of cells moves the ring
// by one position per cycle. One operation is in flight at a time, so a new one is taken
// only once the last one's result is registered; a new one is taken while a result waits.
// Reset (synchronous, active low) empties the queue and sets the slice tick count to 4.
// ----------------------------------------------------------------------------
// Run queue with priority select
// Circular run queue of process ids kept in queue order in a chain of cells,
// with push, pop, unlink, rotate, member test, top priority select, clear and status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module process_ring_queue_priority_select #(
    parameter int MAX_PROCS = prqps_pkg::MAX_PROCS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prqps_req_if.sink   i_req,
    prqps_rsp_if.source o_rsp,
    prqps_cfg_if.sink   i_cfg
);
    import prqps_pkg::*;

    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                 r_state,    n_state;
    logic [CW-1:0]          r_count,    n_count;
    logic [MAX_PROCS-1:0]   r_member,   n_member;
    logic [TQ_W-1:0]        r_tq,       n_tq;
    t_op                    r_op,       n_op;
    logic [ID_W-1:0]        r_target,   n_target;
    logic [CW-1:0]          r_steps,    n_steps;
    t_status                r_status,   n_status;
    logic                   r_found,    n_found;
    logic [LEVEL_W-1:0]     r_level,    n_level;
    logic [ID_W-1:0]        r_best_id,  n_best_id;
    logic [PRI_W:0]         r_best_pri, n_best_pri;
    logic                   r_out_valid, n_out_valid;
    t_rsp                   r_out,      n_out;

    t_cell_ctl              w_ctl;
    logic [CW-1:0]          w_pos;
    t_slot                  w_push;
    t_slot                  w_slot [MAX_PROCS];
    t_slot                  w_head;
    t_op                    w_op;
    logic [IW-1:0]          w_req_idx;
    logic                   w_in_range;
    logic                   w_req_member;
    logic                   w_full;
    logic                   w_hit;
    logic [LEVEL_W-1:0]     w_level;
    logic                   w_sel_ok;
    logic                   w_walk;
    logic                   w_walk_fixed;
    logic                   w_count_ok;

    // ---------------- chain of cells ----------------
    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        t_slot w_right;
        if (g < MAX_PROCS - 1) begin : g_mid
            assign w_right = w_slot[g+1];
        end else begin : g_last
            assign w_right = '0;
        end
        prqps_cell #(
            .MAX_PROCS (MAX_PROCS),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_push  (w_push),
            .i_right (w_right),
            .i_head  (w_head),
            .o_slot  (w_slot[g])
        );
    end

    assign w_head = w_slot[0];

    // ---------------- decode ----------------
    assign w_op         = t_op'(i_req.opcode);
    assign w_req_idx    = IW'(i_req.proc_id);
    assign w_in_range   = (32'(i_req.proc_id) < 32'(MAX_PROCS));
    assign w_req_member = w_in_range && r_member[w_req_idx];
    assign w_full       = (r_count >= CW'(MAX_PROCS));
    assign w_hit        = (w_head.id == r_target);
    assign w_level      = (r_tq >= TQ_OFFSET) ? LEVEL_W'((r_tq - TQ_OFFSET) >> 1) : '0;
    assign w_sel_ok     = (r_op == OP_SELECT) && (r_status == ST_OK);
    assign w_push.id    = i_req.proc_id;
    assign w_push.pri   = i_req.entry_priority;

    // No beat is taken while reset is held.
    assign i_req.ready  = (r_state == S_IDLE) && i_rst_n;
    assign i_cfg.ready  = i_rst_n;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_member    = r_member;
        n_tq        = r_tq;
        n_op        = r_op;
        n_target    = r_target;
        n_steps     = r_steps;
        n_status    = r_status;
        n_found     = r_found;
        n_level     = r_level;
        n_best_id   = r_best_id;
        n_best_pri  = r_best_pri;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ctl       = '0;
        w_pos       = r_count - CW'(1);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg.valid) begin
            n_tq = i_cfg.slice_ticks;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = w_op;
                    n_target = i_req.proc_id;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_level  = '0;
                    n_state  = S_DONE;
                    unique case (w_op)
                        OP_PUSH: begin
                            if (w_full || !w_in_range) begin
                                n_status = ST_FULL;
                            end else if (r_member[w_req_idx]) begin
                                n_status = ST_DUP;
                            end else begin
                                w_ctl.load            = 1'b1;
                                w_pos                 = r_count;
                                n_member[w_req_idx]   = 1'b1;
                                n_count               = r_count + CW'(1);
                                n_level               = w_level;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // Drop the front entry; everything moves one place on.
                                w_ctl.shift              = 1'b1;
                                n_member[IW'(w_head.id)] = 1'b0;
                                n_count                  = r_count - CW'(1);
                            end
                        end
                        OP_UNLINK: begin
                            if (!w_req_member) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_member[w_req_idx] = 1'b0;
                                n_steps             = r_count;
                                n_state             = S_WALK;
                            end
                        end
                        OP_ROTATE: begin
                            if (!w_req_member) begin
                                n_status = ST_ABSENT;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        OP_TEST: begin
                            n_found = w_req_member;
                        end
                        OP_SELECT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_best_pri = PRI_NONE;
                                n_best_id  = w_head.id;
                                n_steps    = r_count;
                                n_state    = S_WALK;
                            end
                        end
                        OP_CLEAR: begin
                            n_member = '0;
                            n_count  = '0;
                        end
                        OP_STATUS: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_op == OP_ROTATE) begin
                    // Spin the ring until the target sits at the front.
                    if (w_hit) begin
                        n_state = S_DONE;
                    end else begin
                        w_ctl.shift = 1'b1;
                        w_ctl.keep  = 1'b1;
                    end
                end else begin
                    // One full turn of the ring: each entry passes the front once.
                    w_ctl.shift = 1'b1;
                    w_ctl.keep  = !((r_op == OP_UNLINK) && w_hit);
                    if ((r_op == OP_UNLINK) && w_hit) begin
                        n_count = r_count - CW'(1);
                    end
                    if ((r_op == OP_SELECT) && ({1'b0, w_head.pri} < r_best_pri)) begin
                        n_best_pri = {1'b0, w_head.pri};
                        n_best_id  = w_head.id;
                    end
                    n_steps = r_steps - CW'(1);
                    if (r_steps == CW'(1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = r_status;
                    n_out.found          = r_found;
                    n_out.selected_id    = w_sel_ok ? r_best_id : '0;
                    n_out.selected_valid = w_sel_ok;
                    n_out.front_id       = (r_count != '0) ? w_head.id : '0;
                    n_out.queue_empty    = (r_count == '0);
                    n_out.entry_count    = COUNT_W'(r_count);
                    n_out.pushed_level   = r_level;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_member    <= '0;
            r_tq        <= TQ_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_member    <= n_member;
            r_tq        <= n_tq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_target   <= n_target;
        r_steps    <= n_steps;
        r_status   <= n_status;
        r_found    <= n_found;
        r_level    <= n_level;
        r_best_id  <= n_best_id;
        r_best_pri <= n_best_pri;
        r_out      <= n_out;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.found          = r_out.found;
    assign o_rsp.selected_id    = r_out.selected_id;
    assign o_rsp.selected_valid = r_out.selected_valid;
    assign o_rsp.front_id       = r_out.front_id;
    assign o_rsp.queue_empty    = r_out.queue_empty;
    assign o_rsp.entry_count    = r_out.entry_count;
    assign o_rsp.pushed_level   = r_out.pushed_level;

    // ---------------- assertions ----------------
    assign w_walk       = (r_state == S_WALK);
    assign w_walk_fixed = w_walk && (r_op != OP_UNLINK);
    assign w_count_ok   = ($countones(r_member) == int'(r_count));

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(MAX_PROCS), "count above capacity")
    `ASSERT_IMPLY(a_member_count, i_clk, i_rst_n, !w_walk, w_count_ok, "member flags off count")
    `ASSERT_NEXT(a_walk_keeps_count, i_clk, i_rst_n, w_walk_fixed, $stable(r_count), "walk moved count")

endmodule
